// ----- rtl/core/fis_pkg.sv -----
package fis_pkg;

   localparam int unsigned WINDOW_DEPTH = 16;
   localparam int unsigned IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int unsigned FILL_W       = $clog2(WINDOW_DEPTH + 1);

   localparam int unsigned TS_W       = 32;
   localparam int unsigned SUM_W      = TS_W + IDX_W;
   localparam int unsigned DIV_CNT_W  = $clog2(SUM_W);
   localparam int unsigned RATE_W     = 28;
   localparam int unsigned TARGET_W   = 10;
   localparam int unsigned SUGGEST_W  = 8;
   localparam int unsigned HELD_W     = 5;
   localparam int unsigned RSP_DATA_W = 104;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [RATE_W-1:0]   RATE_SCALE    = 28'd256000000;
   localparam logic [TARGET_W-1:0] TARGET_RESET  = 10'd100;

   // 3*avg compared against 2*limit*256
   localparam logic [RATE_W+1:0] SUG_LIM_200 = 30'd92160;
   localparam logic [RATE_W+1:0] SUG_LIM_150 = 30'd71680;
   localparam logic [RATE_W+1:0] SUG_LIM_100 = 30'd46080;
   localparam logic [RATE_W+1:0] SUG_LIM_75  = 30'd33280;

   localparam logic [SUGGEST_W-1:0] SUGGEST_200 = 8'd200;
   localparam logic [SUGGEST_W-1:0] SUGGEST_150 = 8'd150;
   localparam logic [SUGGEST_W-1:0] SUGGEST_100 = 8'd100;
   localparam logic [SUGGEST_W-1:0] SUGGEST_75  = 8'd75;
   localparam logic [SUGGEST_W-1:0] SUGGEST_50  = 8'd50;

   localparam logic [CSR_ADDR_W-3:0] REG_TARGET_RATE = '0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FINISH
   } fis_state_type;

   typedef enum logic [1:0] {
      OP_MEAN,
      OP_AVG,
      OP_MIN,
      OP_MAX
   } fis_op_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [TS_W-1:0]  divisor;
   } fis_div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [SUM_W-1:0] quotient;
   } fis_div_rsp_type;

endpackage

// ----- rtl/core/fis_ram.sv -----
module fis_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/fis_div.sv -----
module fis_div (
   input  logic                    clock,
   input  logic                    reset,
   input  fis_pkg::fis_div_req_type req,
   output fis_pkg::fis_div_rsp_type rsp
);

   logic [fis_pkg::TS_W-1:0]      rem_ff,  rem_in;
   logic [fis_pkg::SUM_W-1:0]     quo_ff,  quo_in;
   logic [fis_pkg::TS_W-1:0]      dvs_ff,  dvs_in;
   logic [fis_pkg::DIV_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   logic [fis_pkg::TS_W:0] trial;
   logic [fis_pkg::TS_W:0] diff;
   logic                   fits;

   assign trial = {rem_ff, quo_ff[fis_pkg::SUM_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[fis_pkg::TS_W-1:0] : trial[fis_pkg::TS_W-1:0];
         quo_in = {quo_ff[fis_pkg::SUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == fis_pkg::DIV_CNT_W'(fis_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ----- rtl/core/frame_interval_statistics.sv -----
// Frame interval statistics.
// req channel: one transfer per frame event. req_tuser = 1 clears the history,
// req_tuser = 0 records req_tdata as a frame timestamp in microseconds.
// rsp channel: exactly one transfer per req transfer, in order, carrying the
// average, minimum and maximum rate (1/256 Hz), the too-low flag, the
// suggested sensor rate and the number of stored intervals.
// csr port: register 0 at byte address 0 is target_rate_hz (10 bits, reset 100).
// The ring walk does one RAM read per cycle; one radix-2 divider then runs
// mean, average, minimum and maximum rate in turn, 36 steps each.
// A division by a zero interval skips the divider and yields zero.
// One item at a time: req_tready is high only while the block is idle.
// A finished result sits in the output register; if rsp_tready is low the
// next item may still be accepted and computed, and it waits at the end
// until the output register frees up.
// Reset (synchronous) empties the window and sets the target rate to 100 Hz;
// the ring RAM is not cleared, entries are read only after being written.
module frame_interval_statistics (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fis_pkg::TS_W-1:0]         req_tdata,   // [31:0] timestamp_us
   input  logic                             req_tuser,   // [0] action
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [27:0] average_rate, [55:28] minimum_rate, [83:56] maximum_rate,
   // [84] rate_too_low, [92:85] suggested_rate_hz, [97:93] intervals_held
   output logic [fis_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fis_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [fis_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [fis_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   fis_pkg::fis_state_type state_ff, state_in;
   fis_pkg::fis_op_type    op_ff, op_in;

   logic [fis_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic [fis_pkg::IDX_W-1:0]    oldest_ff, oldest_in;
   logic                         seen_ff, seen_in;
   logic [fis_pkg::TS_W-1:0]     prev_ff, prev_in;
   logic [fis_pkg::TARGET_W-1:0] target_ff, target_in;
   logic [fis_pkg::FILL_W-1:0]   walk_ff, walk_in;
   logic                         pend_ff, pend_in;
   logic [fis_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [fis_pkg::TS_W-1:0]     lo_ff, lo_in;
   logic [fis_pkg::TS_W-1:0]     hi_ff, hi_in;
   logic [fis_pkg::TS_W-1:0]     mean_ff, mean_in;
   logic [fis_pkg::RATE_W-1:0]   avg_ff, avg_in;
   logic [fis_pkg::RATE_W-1:0]   minr_ff, minr_in;
   logic [fis_pkg::RATE_W-1:0]   maxr_ff, maxr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fis_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic accept, csr_wr, csr_hit;
   logic rd_issue, walk_done, div_zero, res_take, load_out, out_free;
   logic ram_we;
   logic [fis_pkg::IDX_W-1:0] ram_waddr;
   logic [fis_pkg::TS_W-1:0]  ram_rdata;
   logic [fis_pkg::TS_W-1:0]  delta;
   logic [fis_pkg::SUM_W-1:0] div_value;
   logic                      too_low;
   logic [fis_pkg::SUGGEST_W-1:0] suggest;
   logic [fis_pkg::RATE_W+1:0]    avg3;
   logic [fis_pkg::RATE_W-1:0]    half_target;

   fis_pkg::fis_div_req_type div_req;
   fis_pkg::fis_div_rsp_type div_rsp;

   // config port
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[fis_pkg::CSR_ADDR_W-1:2] == fis_pkg::REG_TARGET_RATE;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_prdata = csr_hit ? fis_pkg::CSR_DATA_W'(target_ff) : '0;
   assign target_in  = csr_wr ? csr_pwdata[fis_pkg::TARGET_W-1:0] : target_ff;

   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign walk_done = (walk_ff == fill_ff) && !pend_ff;
   assign delta     = req_tdata - prev_ff;
   assign ram_waddr = (fill_ff < fis_pkg::FILL_W'(fis_pkg::WINDOW_DEPTH))
                      ? fill_ff[fis_pkg::IDX_W-1:0] : oldest_ff;

   fis_ram #(
      .WIDTH (fis_pkg::TS_W),
      .DEPTH (fis_pkg::WINDOW_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (delta),
      .raddr (walk_ff[fis_pkg::IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      div_req.dividend = fis_pkg::SUM_W'(fis_pkg::RATE_SCALE);
      div_req.divisor  = lo_ff;
      case (op_ff)
         fis_pkg::OP_MEAN: begin
            div_req.dividend = sum_ff;
            div_req.divisor  = fis_pkg::TS_W'(fill_ff);
         end
         fis_pkg::OP_AVG: div_req.divisor = mean_ff;
         fis_pkg::OP_MIN: div_req.divisor = hi_ff;
         fis_pkg::OP_MAX: div_req.divisor = lo_ff;
         default: div_req.divisor = lo_ff;
      endcase
      div_req.start = (state_ff == fis_pkg::ST_DIV_START) && (div_req.divisor != '0);
   end

   assign div_zero      = div_req.divisor == '0;
   assign div_value     = div_zero ? '0 : div_rsp.quotient;

   fis_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fis_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = fis_pkg::ST_WALK;
         end
         fis_pkg::ST_WALK: begin
            if (walk_done) begin
               state_in = (fill_ff == '0) ? fis_pkg::ST_FINISH : fis_pkg::ST_DIV_START;
            end
         end
         fis_pkg::ST_DIV_START: begin
            if (!div_zero) begin
               state_in = fis_pkg::ST_DIV_WAIT;
            end else if (op_ff == fis_pkg::OP_MAX) begin
               state_in = fis_pkg::ST_FINISH;
            end
         end
         fis_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = (op_ff == fis_pkg::OP_MAX) ? fis_pkg::ST_FINISH
                                                     : fis_pkg::ST_DIV_START;
            end
         end
         fis_pkg::ST_FINISH: begin
            if (out_free) state_in = fis_pkg::ST_IDLE;
         end
         default: state_in = fis_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      rd_issue   = 1'b0;
      res_take   = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         fis_pkg::ST_IDLE:      req_tready = 1'b1;
         fis_pkg::ST_WALK:      rd_issue   = walk_ff < fill_ff;
         fis_pkg::ST_DIV_START: res_take   = div_zero;
         fis_pkg::ST_DIV_WAIT:  res_take   = div_rsp.done;
         fis_pkg::ST_FINISH:    load_out   = out_free;
         default:               req_tready = 1'b0;
      endcase
   end

   assign ram_we = accept && !req_tuser && seen_ff;

   assign avg3        = {2'b00, avg_ff} + {1'b0, avg_ff, 1'b0};
   assign half_target = fis_pkg::RATE_W'({target_ff, 7'b0});

   always_comb begin
      too_low = 1'b1;
      suggest = fis_pkg::SUGGEST_100;
      if (avg_ff != '0) begin
         too_low = avg_ff < half_target;
         if (avg3 >= fis_pkg::SUG_LIM_200) begin
            suggest = fis_pkg::SUGGEST_200;
         end else if (avg3 >= fis_pkg::SUG_LIM_150) begin
            suggest = fis_pkg::SUGGEST_150;
         end else if (avg3 >= fis_pkg::SUG_LIM_100) begin
            suggest = fis_pkg::SUGGEST_100;
         end else if (avg3 >= fis_pkg::SUG_LIM_75) begin
            suggest = fis_pkg::SUGGEST_75;
         end else begin
            suggest = fis_pkg::SUGGEST_50;
         end
      end
   end

   // datapath
   always_comb begin
      fill_in   = fill_ff;
      oldest_in = oldest_ff;
      seen_in   = seen_ff;
      prev_in   = prev_ff;
      walk_in   = walk_ff;
      pend_in   = rd_issue;
      sum_in    = sum_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      op_in     = op_ff;
      mean_in   = mean_ff;
      avg_in    = avg_ff;
      minr_in   = minr_ff;
      maxr_in   = maxr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (accept) begin
         walk_in = '0;
         sum_in  = '0;
         lo_in   = '1;
         hi_in   = '0;
         op_in   = fis_pkg::OP_MEAN;
         avg_in  = '0;
         minr_in = '0;
         maxr_in = '0;
         if (req_tuser) begin
            fill_in   = '0;
            oldest_in = '0;
            seen_in   = 1'b0;
            prev_in   = '0;
         end else begin
            if (seen_ff) begin
               if (fill_ff < fis_pkg::FILL_W'(fis_pkg::WINDOW_DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end else if (oldest_ff == fis_pkg::IDX_W'(fis_pkg::WINDOW_DEPTH - 1)) begin
                  oldest_in = '0;
               end else begin
                  oldest_in = oldest_ff + 1'b1;
               end
            end
            prev_in = req_tdata;
            seen_in = 1'b1;
         end
      end

      if (rd_issue) walk_in = walk_ff + 1'b1;

      if (pend_ff) begin
         sum_in = sum_ff + fis_pkg::SUM_W'(ram_rdata);
         if (ram_rdata < lo_ff) lo_in = ram_rdata;
         if (ram_rdata > hi_ff) hi_in = ram_rdata;
      end

      if (res_take) begin
         case (op_ff)
            fis_pkg::OP_MEAN: begin
               mean_in = div_value[fis_pkg::TS_W-1:0];
               op_in   = fis_pkg::OP_AVG;
            end
            fis_pkg::OP_AVG: begin
               avg_in = div_value[fis_pkg::RATE_W-1:0];
               op_in  = fis_pkg::OP_MIN;
            end
            fis_pkg::OP_MIN: begin
               minr_in = div_value[fis_pkg::RATE_W-1:0];
               op_in   = fis_pkg::OP_MAX;
            end
            fis_pkg::OP_MAX: maxr_in = div_value[fis_pkg::RATE_W-1:0];
            default: op_in = fis_pkg::OP_MEAN;
         endcase
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fis_pkg::RSP_DATA_W'({fis_pkg::HELD_W'(fill_ff), suggest, too_low,
                                               maxr_ff, minr_ff, avg_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fis_pkg::ST_IDLE;
         op_ff        <= fis_pkg::OP_MEAN;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         seen_ff      <= 1'b0;
         prev_ff      <= '0;
         target_ff    <= fis_pkg::TARGET_RESET;
         walk_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         seen_ff      <= seen_in;
         prev_ff      <= prev_in;
         target_ff    <= target_in;
         walk_ff      <= walk_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff      <= sum_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mean_ff     <= mean_in;
      avg_ff      <= avg_in;
      minr_ff     <= minr_in;
      maxr_ff     <= maxr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= fis_pkg::FILL_W'(fis_pkg::WINDOW_DEPTH))
      else $error("window fill beyond depth");

   a_oldest_full: assert property (@(posedge clock) disable iff (reset)
      oldest_ff != '0 |-> fill_ff == fis_pkg::FILL_W'(fis_pkg::WINDOW_DEPTH))
      else $error("ring wrapped before window full");

   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_rsp.busy)
      else $error("divider busy while accepting");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_tvalid)
      else $error("result load lost");

   a_wait_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fis_pkg::ST_DIV_WAIT) |-> (div_rsp.busy || div_rsp.done))
      else $error("waiting on idle divider");

endmodule
